// ===== rtl/rvm_pkg.sv =====
// rvm_pkg: opcodes, error codes, instruction byte lengths and shared types
// for the register machine execute unit. Depends on nothing.

package rvm_pkg;

    // Instruction opcodes
    localparam logic [7:0] OP_HALT  = 8'd0;
    localparam logic [7:0] OP_LOADI = 8'd1;
    localparam logic [7:0] OP_ADD   = 8'd2;
    localparam logic [7:0] OP_SUB   = 8'd3;
    localparam logic [7:0] OP_MUL   = 8'd4;
    localparam logic [7:0] OP_DIV   = 8'd5;
    localparam logic [7:0] OP_PRINT = 8'd6;
    localparam logic [7:0] OP_JUMP  = 8'd7;
    localparam logic [7:0] OP_JZ    = 8'd8;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DIV0   = 2'd1;
    localparam logic [1:0] ERR_OPCODE = 2'd2;

    // Instruction byte lengths
    localparam logic [3:0] LEN_HALT  = 4'd1;
    localparam logic [3:0] LEN_ARITH = 4'd4;
    localparam logic [3:0] LEN_PRINT = 4'd2;
    localparam logic [3:0] LEN_WIDE  = 4'd10;

    // Operation of the shared arithmetic unit
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    // Request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

// ===== rtl/register_vm_instruction_execute_unit.sv =====
// Register machine instruction execute unit: sequencer, program counter and
// output register. Uses rvm_pkg, rvm_regfile and rvm_alu.
//
// Usage: each input word is one decoded instruction (opcode, register fields,
// 64-bit immediate). It is accepted when i_valid is high and o_stall is low.
// Each instruction gives exactly one result word (next_pc, print data, halt
// flag, error code), offered with o_valid and taken when i_stall is low.
// Halt, loadi, print, jumps, illegal opcodes and divide by zero go from
// S_EXEC straight to write-back; add, subtract, multiply and divide wait in
// S_WAIT for the shared 65-bit adder, which for multiply and divide resolves
// one multiplier or quotient bit per cycle. One instruction is in flight at a
// time; o_stall drops again the cycle after write-back, so a new word can be
// taken once the previous result is loaded.
// Reset clears the register file (all zero), the program counter and all
// control state. A stalled result stays in the output register; the next
// instruction runs meanwhile but waits before write-back until the output
// register is free.

module register_vm_instruction_execute_unit #(
    parameter int  NUM_REGS = 8,
    localparam int IDX_W    = $clog2(NUM_REGS)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_opcode,
    input  logic [2:0]  i_dest_reg,
    input  logic [2:0]  i_src1_reg,
    input  logic [2:0]  i_src2_reg,
    input  logic [63:0] i_immediate,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_next_pc,
    output logic        o_print_valid,
    output logic [2:0]  o_print_reg,
    output logic [63:0] o_print_value,
    output logic        o_halted,
    output logic [1:0]  o_error_code
);
    import rvm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAIT = 4'b0100,
        S_WB   = 4'b1000
    } t_state;

    // Wrap a register field into the file: small constant lookup per field value
    function automatic logic [IDX_W-1:0] f_reg_idx(input logic [2:0] fld);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < 8; k++) begin
            if (fld == 3'(k)) begin
                idx = IDX_W'(k % NUM_REGS);
            end
        end
        return idx;
    endfunction

    t_state           r_state, n_state;
    logic [63:0]      r_pc, n_pc;
    logic [7:0]       r_op, n_op;
    logic [IDX_W-1:0] r_dest, n_dest;
    logic [2:0]       r_src1, n_src1;
    logic [63:0]      r_imm, n_imm;
    logic [63:0]      r_npc, n_npc;
    logic             r_wr_en, n_wr_en;
    logic             r_use_alu, n_use_alu;
    logic [63:0]      r_wdata, n_wdata;
    logic             r_pv, n_pv;
    logic [63:0]      r_pval, n_pval;
    logic             r_halt, n_halt;
    logic [1:0]       r_err, n_err;
    logic             r_out_valid, n_out_valid;
    logic [63:0]      r_o_npc, n_o_npc;
    logic             r_o_pv, n_o_pv;
    logic [2:0]       r_o_preg, n_o_preg;
    logic [63:0]      r_o_pval, n_o_pval;
    logic             r_o_halt, n_o_halt;
    logic [1:0]       r_o_err, n_o_err;

    logic             w_accept;
    logic             w_out_free;
    logic             w_rf_wr;
    logic [63:0]      w_rf_wdata;
    logic [63:0]      w_opa;
    logic [63:0]      w_opb;
    t_alu_req         w_alu_req;
    logic             w_alu_done;
    logic [63:0]      w_alu_result;
    logic [3:0]       w_len;
    logic [63:0]      w_pc_inc;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_rf_wr    = (r_state == S_WB) && w_out_free && r_wr_en;
    assign w_rf_wdata = r_use_alu ? w_alu_result : r_wdata;

    rvm_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_rf_wr),
        .i_wr_addr   (r_dest),
        .i_wr_data   (w_rf_wdata),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (f_reg_idx(i_src1_reg)),
        .i_rd_addr_b (f_reg_idx(i_src2_reg)),
        .o_rd_data_a (w_opa),
        .o_rd_data_b (w_opb)
    );

    rvm_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_opa    (w_opa),
        .i_opb    (w_opb),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    // Pick the byte length for the sequential program counter step
    always_comb begin
        case (r_op)
            OP_HALT:                         w_len = LEN_HALT;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:  w_len = LEN_ARITH;
            OP_PRINT:                        w_len = LEN_PRINT;
            default:                         w_len = LEN_WIDE;
        endcase
    end

    assign w_pc_inc = r_pc + 64'(w_len);

    // Sequencer: capture, decode, wait for the unit, write back
    always_comb begin
        n_state       = r_state;
        n_pc          = r_pc;
        n_op          = r_op;
        n_dest        = r_dest;
        n_src1        = r_src1;
        n_imm         = r_imm;
        n_npc         = r_npc;
        n_wr_en       = r_wr_en;
        n_use_alu     = r_use_alu;
        n_wdata       = r_wdata;
        n_pv          = r_pv;
        n_pval        = r_pval;
        n_halt        = r_halt;
        n_err         = r_err;
        w_alu_req     = '{start: 1'b0, op: ALU_ADD};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op      = i_opcode;
                    n_dest    = f_reg_idx(i_dest_reg);
                    n_src1    = i_src1_reg;
                    n_imm     = i_immediate;
                    n_wr_en   = 1'b0;
                    n_use_alu = 1'b0;
                    n_pv      = 1'b0;
                    n_pval    = 64'd0;
                    n_halt    = 1'b0;
                    n_err     = ERR_NONE;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_WB;
                case (r_op)
                    OP_HALT: begin
                        n_halt = 1'b1;
                        n_npc  = w_pc_inc;
                    end
                    OP_LOADI: begin
                        n_wr_en = 1'b1;
                        n_wdata = r_imm;
                        n_npc   = w_pc_inc;
                    end
                    OP_ADD, OP_SUB, OP_MUL: begin
                        w_alu_req.start = 1'b1;
                        w_alu_req.op    = (r_op == OP_ADD) ? ALU_ADD :
                                          (r_op == OP_SUB) ? ALU_SUB : ALU_MUL;
                        n_wr_en   = 1'b1;
                        n_use_alu = 1'b1;
                        n_npc     = w_pc_inc;
                        n_state   = S_WAIT;
                    end
                    OP_DIV: begin
                        if (w_opb == 64'd0) begin
                            n_err = ERR_DIV0;
                            n_npc = r_pc;
                        end else begin
                            w_alu_req.start = 1'b1;
                            w_alu_req.op    = ALU_DIV;
                            n_wr_en   = 1'b1;
                            n_use_alu = 1'b1;
                            n_npc     = w_pc_inc;
                            n_state   = S_WAIT;
                        end
                    end
                    OP_PRINT: begin
                        n_pv   = 1'b1;
                        n_pval = w_opa;
                        n_npc  = w_pc_inc;
                    end
                    OP_JUMP: begin
                        n_npc = r_imm;
                    end
                    OP_JZ: begin
                        n_npc = (w_opa == 64'd0) ? r_imm : w_pc_inc;
                    end
                    default: begin
                        n_err = ERR_OPCODE;
                        n_npc = r_pc;
                    end
                endcase
            end
            S_WAIT: begin
                if (w_alu_done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (w_out_free) begin
                    n_pc    = r_npc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load at write-back, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_o_npc     = r_o_npc;
        n_o_pv      = r_o_pv;
        n_o_preg    = r_o_preg;
        n_o_pval    = r_o_pval;
        n_o_halt    = r_o_halt;
        n_o_err     = r_o_err;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_WB && w_out_free) begin
            n_out_valid = 1'b1;
            n_o_npc     = r_npc;
            n_o_pv      = r_pv;
            n_o_preg    = r_pv ? r_src1 : 3'd0;
            n_o_pval    = r_pval;
            n_o_halt    = r_halt;
            n_o_err     = r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= 64'd0;
            r_out_valid <= 1'b0;
            r_wr_en     <= 1'b0;
            r_use_alu   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_wr_en     <= n_wr_en;
            r_use_alu   <= n_use_alu;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_dest   <= n_dest;
        r_src1   <= n_src1;
        r_imm    <= n_imm;
        r_npc    <= n_npc;
        r_wdata  <= n_wdata;
        r_pv     <= n_pv;
        r_pval   <= n_pval;
        r_halt   <= n_halt;
        r_err    <= n_err;
        r_o_npc  <= n_o_npc;
        r_o_pv   <= n_o_pv;
        r_o_preg <= n_o_preg;
        r_o_pval <= n_o_pval;
        r_o_halt <= n_o_halt;
        r_o_err  <= n_o_err;
    end

    assign o_valid       = r_out_valid;
    assign o_next_pc     = r_o_npc;
    assign o_print_valid = r_o_pv;
    assign o_print_reg   = r_o_preg;
    assign o_print_value = r_o_pval;
    assign o_halted      = r_o_halt;
    assign o_error_code  = r_o_err;

`ifndef NO_ASSERTIONS
    // The arithmetic unit finishes only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> (r_state == S_WAIT))
        else $error("arithmetic unit finished outside the wait state");

    // A faulting instruction never writes the register file
    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && r_err != ERR_NONE) |-> !r_wr_en)
        else $error("register write scheduled for a faulting instruction");

    // A new result appears only out of write-back
    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_WB))
        else $error("result word loaded outside write-back");

    // An error leaves the program counter where it was
    a_error_holds_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && w_out_free && r_err != ERR_NONE) |-> (r_npc == r_pc))
        else $error("faulting instruction moved the program counter");
`endif

endmodule

// ===== rtl/rvm_regfile.sv =====
// rvm_regfile: register file memory with one write port, two registered read
// ports and per-entry valid bits so unwritten entries read as zero. Uses rvm_pkg.

module rvm_regfile #(
    parameter int  NUM_REGS = 8,
    localparam int IDX_W    = $clog2(NUM_REGS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [63:0]      i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr_a,
    input  logic [IDX_W-1:0] i_rd_addr_b,
    output logic [63:0]      o_rd_data_a,
    output logic [63:0]      o_rd_data_b
);
    import rvm_pkg::*;

    logic [63:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [63:0]         r_dat_a;
    logic [63:0]         r_dat_b;
    logic                r_vld_a;
    logic                r_vld_b;

    // Write the memory array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark written entries; reset returns every entry to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Read both ports into registers, hold between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_dat_a <= r_mem[i_rd_addr_a];
            r_dat_b <= r_mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_rd_en) begin
            r_vld_a <= r_vld[i_rd_addr_a];
            r_vld_b <= r_vld[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_vld_a ? r_dat_a : 64'd0;
    assign o_rd_data_b = r_vld_b ? r_dat_b : 64'd0;

endmodule

// ===== rtl/rvm_alu.sv =====
// rvm_alu: shared iterative arithmetic unit built around one 65-bit adder.
// Add and subtract take one step; multiply and divide take 64. Uses rvm_pkg.

module rvm_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rvm_pkg::t_alu_req i_req,
    input  logic [63:0]       i_opa,
    input  logic [63:0]       i_opb,
    output logic              o_done,
    output logic [63:0]       o_result
);
    import rvm_pkg::*;

    logic        r_busy, n_busy;
    t_alu_op     r_op, n_op;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_u, n_u;      // addend a, multiplicand, dividend/quotient
    logic [63:0] r_v, n_v;      // addend b, multiplier, divisor
    logic [63:0] r_w, n_w;      // result, product, remainder
    logic [64:0] w_x;
    logic [64:0] w_y;
    logic        w_sub;
    logic [65:0] w_sum;

    // Select operands of the shared adder
    always_comb begin
        case (r_op)
            ALU_ADD: begin
                w_x   = {1'b0, r_u};
                w_y   = {1'b0, r_v};
                w_sub = 1'b0;
            end
            ALU_SUB: begin
                w_x   = {1'b0, r_u};
                w_y   = {1'b0, r_v};
                w_sub = 1'b1;
            end
            ALU_MUL: begin
                w_x   = {1'b0, r_w};
                w_y   = {1'b0, r_u};
                w_sub = 1'b0;
            end
            ALU_DIV: begin
                w_x   = {r_w, r_u[63]};
                w_y   = {1'b0, r_v};
                w_sub = 1'b1;
            end
            default: begin
                w_x   = {1'b0, r_u};
                w_y   = {1'b0, r_v};
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_sum = {1'b0, w_x} + {1'b0, w_y ^ {65{w_sub}}} + 66'(w_sub);

    // Load on start, then advance one step per cycle
    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_u    = r_u;
        n_v    = r_v;
        n_w    = r_w;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = (i_req.op == ALU_MUL || i_req.op == ALU_DIV) ? 6'd63 : 6'd0;
            n_u    = i_opa;
            n_v    = i_opb;
            n_w    = 64'd0;
        end else if (r_busy) begin
            case (r_op)
                ALU_ADD, ALU_SUB: begin
                    n_w = w_sum[63:0];
                end
                ALU_MUL: begin
                    if (r_v[0]) begin
                        n_w = w_sum[63:0];
                    end
                    n_u = {r_u[62:0], 1'b0};
                    n_v = {1'b0, r_v[63:1]};
                end
                ALU_DIV: begin
                    // carry out set means the trial subtract did not borrow
                    n_w = w_sum[65] ? w_sum[63:0] : w_x[63:0];
                    n_u = {r_u[62:0], w_sum[65]};
                end
                default: begin
                    n_w = w_sum[63:0];
                end
            endcase
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= ALU_ADD;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_v <= n_v;
        r_w <= n_w;
    end

    assign o_done   = r_busy && (r_cnt == 6'd0);
    assign o_result = (r_op == ALU_DIV) ? r_u : r_w;

endmodule
